// ----- rtl/mlpl_pkg.sv -----
package mlpl_pkg;

    localparam logic [7:0]  MAGIC_B         = 8'h42;
    localparam logic [7:0]  MAGIC_O         = 8'h4F;
    localparam logic [7:0]  MAGIC_T         = 8'h54;
    localparam logic [31:0] LOAD_BASE_RESET = 32'h0020_0000;

    typedef enum logic [1:0] {
        EV_WRITE = 2'd0,
        EV_FINAL = 2'd1,
        EV_EMPTY = 2'd2
    } t_event;

    typedef enum logic [9:0] {
        PH_HUNT    = 10'b00_0000_0001,
        PH_MAG1    = 10'b00_0000_0010,
        PH_MAG2    = 10'b00_0000_0100,
        PH_MAG3    = 10'b00_0000_1000,
        PH_LEN0    = 10'b00_0001_0000,
        PH_LEN1    = 10'b00_0010_0000,
        PH_LEN2    = 10'b00_0100_0000,
        PH_LEN3    = 10'b00_1000_0000,
        PH_PAYLOAD = 10'b01_0000_0000,
        PH_DONE    = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        t_event      event_res;
        logic [31:0] mem_addr;
        logic [7:0]  mem_data;
        logic [31:0] image_length;
    } t_result;

endpackage

// ----- rtl/mlpl_if.sv -----
interface mlpl_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mlpl_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [31:0] mem_addr;
    logic [7:0]  mem_data;
    logic [31:0] image_length;

    modport source (output valid, output event_res, output mem_addr, output mem_data,
                    output image_length, input ready);
    modport sink (input valid, input event_res, input mem_addr, input mem_data,
                  input image_length, output ready);
endinterface

interface mlpl_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] load_base;

    modport source (output valid, output load_base, input ready);
    modport sink (input valid, input load_base, output ready);
endinterface

// ----- rtl/magic_length_payload_loader_unit.sv -----
// Serial boot frame loader.
// i_rx carries received bytes, one per transaction. The unit hunts for the
// magic "BOOT", takes a 32-bit little-endian image length from the next four
// bytes, then turns each payload byte into one memory write transaction on
// o_res at load_base plus the byte offset (32-bit wrap). The last write is
// tagged final; a zero length gives a single empty-image transaction.
// After completion every byte is taken and dropped until reset.
// i_cfg writes load_base; it is always ready and is sampled at each write.
// A result is registered; o_res shows it the cycle after its byte is taken.
// Throughput: one byte per cycle while o_res is ready, set by the single
// output register; the frame state updates in the same cycle as the byte
// is taken. When o_res stalls with a result held, i_rx.ready drops until
// the result is taken; bytes that produce no result also wait in that case.
// Reset (synchronous, active low) returns to the hunt, empties the output
// register and restores load_base to 0x0020_0000.
module magic_length_payload_loader_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mlpl_rx_if.sink         i_rx,
    mlpl_res_if.source      o_res,
    mlpl_cfg_if.sink        i_cfg
);

    logic [31:0]       r_load_base;
    logic              fire;
    logic              stage_ready;
    logic              ctrl_valid;
    mlpl_pkg::t_result ctrl_res;
    logic              out_valid;
    mlpl_pkg::t_result out_res;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = stage_ready;
    assign fire        = i_rx.valid && stage_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_base <= mlpl_pkg::LOAD_BASE_RESET;
        end else if (i_cfg.valid) begin
            r_load_base <= i_cfg.load_base;
        end
    end

    mlpl_frame_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_rx_byte   (i_rx.rx_byte),
        .i_load_base (r_load_base),
        .o_res_valid (ctrl_valid),
        .o_res       (ctrl_res)
    );

    mlpl_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && ctrl_valid),
        .i_res   (ctrl_res),
        .o_ready (stage_ready),
        .i_ready (o_res.ready),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    assign o_res.valid        = out_valid;
    assign o_res.event_res    = out_res.event_res;
    assign o_res.mem_addr     = out_res.mem_addr;
    assign o_res.mem_data     = out_res.mem_data;
    assign o_res.image_length = out_res.image_length;

    a_stall_blocks_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !o_res.ready |-> !i_rx.ready)
        else $error("byte taken while result held");

    a_nothing_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && ctrl_valid && (ctrl_res.event_res == mlpl_pkg::EV_FINAL ||
            ctrl_res.event_res == mlpl_pkg::EV_EMPTY) |=> !ctrl_valid)
        else $error("result produced after image complete");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && o_res.event_res == mlpl_pkg::EV_EMPTY |->
            o_res.mem_data == 8'd0 && o_res.image_length == 32'd0)
        else $error("empty image result carries data");

    a_final_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && o_res.event_res == mlpl_pkg::EV_FINAL |-> o_res.image_length != 32'd0)
        else $error("final write with zero length");

endmodule

// ----- rtl/mlpl_frame_ctrl.sv -----
module mlpl_frame_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_rx_byte,
    input  logic [31:0]          i_load_base,
    output logic                 o_res_valid,
    output mlpl_pkg::t_result    o_res
);

    mlpl_pkg::t_phase r_phase;
    mlpl_pkg::t_phase n_phase;
    logic [31:0]      r_length;
    logic [31:0]      n_length;
    logic [31:0]      r_count;
    logic [31:0]      n_count;
    logic [31:0]      count_inc;

    assign count_inc = r_count + 32'd1;

    always_comb begin
        n_phase            = r_phase;
        n_length           = r_length;
        n_count            = r_count;
        o_res_valid        = 1'b0;
        o_res.event_res    = mlpl_pkg::EV_WRITE;
        o_res.mem_addr     = i_load_base + r_count;
        o_res.mem_data     = i_rx_byte;
        case (r_phase)
            mlpl_pkg::PH_HUNT: begin
                n_phase = (i_rx_byte == mlpl_pkg::MAGIC_B) ? mlpl_pkg::PH_MAG1
                                                           : mlpl_pkg::PH_HUNT;
            end
            mlpl_pkg::PH_MAG1: begin
                if (i_rx_byte == mlpl_pkg::MAGIC_O) begin
                    n_phase = mlpl_pkg::PH_MAG2;
                end else begin
                    n_phase = (i_rx_byte == mlpl_pkg::MAGIC_B) ? mlpl_pkg::PH_MAG1
                                                               : mlpl_pkg::PH_HUNT;
                end
            end
            mlpl_pkg::PH_MAG2: begin
                if (i_rx_byte == mlpl_pkg::MAGIC_O) begin
                    n_phase = mlpl_pkg::PH_MAG3;
                end else begin
                    n_phase = (i_rx_byte == mlpl_pkg::MAGIC_B) ? mlpl_pkg::PH_MAG1
                                                               : mlpl_pkg::PH_HUNT;
                end
            end
            mlpl_pkg::PH_MAG3: begin
                if (i_rx_byte == mlpl_pkg::MAGIC_T) begin
                    n_phase  = mlpl_pkg::PH_LEN0;
                    n_length = '0;
                end else begin
                    n_phase = (i_rx_byte == mlpl_pkg::MAGIC_B) ? mlpl_pkg::PH_MAG1
                                                               : mlpl_pkg::PH_HUNT;
                end
            end
            mlpl_pkg::PH_LEN0: begin
                n_length[7:0] = i_rx_byte;
                n_phase       = mlpl_pkg::PH_LEN1;
            end
            mlpl_pkg::PH_LEN1: begin
                n_length[15:8] = i_rx_byte;
                n_phase        = mlpl_pkg::PH_LEN2;
            end
            mlpl_pkg::PH_LEN2: begin
                n_length[23:16] = i_rx_byte;
                n_phase         = mlpl_pkg::PH_LEN3;
            end
            mlpl_pkg::PH_LEN3: begin
                n_length[31:24] = i_rx_byte;
                n_count         = '0;
                if (n_length == 32'd0) begin
                    n_phase         = mlpl_pkg::PH_DONE;
                    o_res_valid     = 1'b1;
                    o_res.event_res = mlpl_pkg::EV_EMPTY;
                    o_res.mem_addr  = i_load_base;
                    o_res.mem_data  = '0;
                end else begin
                    n_phase = mlpl_pkg::PH_PAYLOAD;
                end
            end
            mlpl_pkg::PH_PAYLOAD: begin
                o_res_valid = 1'b1;
                n_count     = count_inc;
                if (count_inc == r_length) begin
                    o_res.event_res = mlpl_pkg::EV_FINAL;
                    n_phase         = mlpl_pkg::PH_DONE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        o_res.image_length = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mlpl_pkg::PH_HUNT;
            r_length <= '0;
            r_count  <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/mlpl_out_stage.sv -----
module mlpl_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  mlpl_pkg::t_result    i_res,
    output logic                 o_ready,
    input  logic                 i_ready,
    output logic                 o_valid,
    output mlpl_pkg::t_result    o_res
);

    logic              r_valid;
    logic              n_valid;
    mlpl_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- tb/mlpl_checker.sv -----
`timescale 1ns / 1ps

module mlpl_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mlpl_rx_if   rx,
    mlpl_res_if  res,
    mlpl_cfg_if  cfg,
    output int   o_errors,
    output int   o_pending
);

    mlpl_pkg::t_result expected_writes[$];
    logic [31:0]       load_base;
    mlpl_pkg::t_phase  phase;
    logic [31:0]       image_len;
    logic [31:0]       offset;
    int                error_count   = 0;
    int                pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mlpl_checker: %0t %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic restart_hunt(input logic [7:0] b);
        phase = (b == mlpl_pkg::MAGIC_B) ? mlpl_pkg::PH_MAG1 : mlpl_pkg::PH_HUNT;
    endtask

    task automatic take_byte(input logic [7:0] b);
        mlpl_pkg::t_result r;
        r = '0;
        case (phase)
            mlpl_pkg::PH_HUNT: restart_hunt(b);
            mlpl_pkg::PH_MAG1: begin
                if (b == mlpl_pkg::MAGIC_O) begin
                    phase = mlpl_pkg::PH_MAG2;
                end else begin
                    restart_hunt(b);
                end
            end
            mlpl_pkg::PH_MAG2: begin
                if (b == mlpl_pkg::MAGIC_O) begin
                    phase = mlpl_pkg::PH_MAG3;
                end else begin
                    restart_hunt(b);
                end
            end
            mlpl_pkg::PH_MAG3: begin
                if (b == mlpl_pkg::MAGIC_T) begin
                    phase     = mlpl_pkg::PH_LEN0;
                    image_len = '0;
                end else begin
                    restart_hunt(b);
                end
            end
            mlpl_pkg::PH_LEN0: begin
                image_len[7:0] = b;
                phase          = mlpl_pkg::PH_LEN1;
            end
            mlpl_pkg::PH_LEN1: begin
                image_len[15:8] = b;
                phase           = mlpl_pkg::PH_LEN2;
            end
            mlpl_pkg::PH_LEN2: begin
                image_len[23:16] = b;
                phase            = mlpl_pkg::PH_LEN3;
            end
            mlpl_pkg::PH_LEN3: begin
                image_len[31:24] = b;
                offset           = '0;
                if (image_len == '0) begin
                    phase          = mlpl_pkg::PH_DONE;
                    r.event_res    = mlpl_pkg::EV_EMPTY;
                    r.mem_addr     = load_base;
                    r.mem_data     = '0;
                    r.image_length = image_len;
                    expected_writes.push_back(r);
                end else begin
                    phase = mlpl_pkg::PH_PAYLOAD;
                end
            end
            mlpl_pkg::PH_PAYLOAD: begin
                r.mem_addr     = load_base + offset;
                r.mem_data     = b;
                r.image_length = image_len;
                offset         = offset + 32'd1;
                if (offset == image_len) begin
                    r.event_res = mlpl_pkg::EV_FINAL;
                    phase       = mlpl_pkg::PH_DONE;
                end else begin
                    r.event_res = mlpl_pkg::EV_WRITE;
                end
                expected_writes.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        mlpl_pkg::t_result want;
        if (expected_writes.size() == 0) begin
            report_mismatch("result with none pending, mem_addr", res.mem_addr, '0);
        end else begin
            want = expected_writes.pop_front();
            if (res.event_res !== want.event_res) begin
                report_mismatch("event_res", {30'd0, res.event_res}, {30'd0, want.event_res});
            end
            if (res.mem_addr !== want.mem_addr) begin
                report_mismatch("mem_addr", res.mem_addr, want.mem_addr);
            end
            if (res.mem_data !== want.mem_data) begin
                report_mismatch("mem_data", {24'd0, res.mem_data}, {24'd0, want.mem_data});
            end
            if (res.image_length !== want.image_length) begin
                report_mismatch("image_length", res.image_length, want.image_length);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_base = mlpl_pkg::LOAD_BASE_RESET;
            phase     = mlpl_pkg::PH_HUNT;
            image_len = '0;
            offset    = '0;
            expected_writes.delete();
        end else begin
            if (rx.valid && rx.ready) begin
                take_byte(rx.rx_byte);
            end
            if (cfg.valid && cfg.ready) begin
                load_base = cfg.load_base;
            end
            if (res.valid && res.ready) begin
                check_result();
            end
        end
        pending_count = expected_writes.size();
    end

endmodule

// ----- tb/tb_magic_length_payload_loader_unit.sv -----
`timescale 1ns / 1ps

module tb_magic_length_payload_loader_unit;

    localparam int NUM_SEGMENTS  = 6;
    localparam int NOISE_BYTES   = 60;
    localparam int TAIL_BYTES    = 20;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_START    = 600;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_START   = 1200;
    localparam int QUIET_END     = 1600;
    localparam int IDLE_PERCENT  = 16;
    localparam int WATCHDOG      = 4000;

    logic i_clk;
    logic i_rst_n;
    int   cyc = 0;
    int   stuck_cycles = 0;
    int   n_errors;
    int   n_pending;
    logic quiet;

    mlpl_rx_if  rx_ch ();
    mlpl_res_if res_ch ();
    mlpl_cfg_if cfg_ch ();

    magic_length_payload_loader_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    mlpl_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg       (cfg_ch),
        .o_errors  (n_errors),
        .o_pending (n_pending)
    );

    // Hunt corner cases: stray T, repeated B, mismatch at each magic position
    logic [7:0] hunt_bytes [19] = '{
        8'h00, 8'hFF, 8'h54, 8'h42, 8'h42, 8'h4F, 8'h58, 8'h42, 8'h4F, 8'h42,
        8'h4F, 8'h4F, 8'h42, 8'h4F, 8'h4F, 8'h00, 8'h42, 8'h4F, 8'h54
    };
    logic [7:0] corner_bytes [9] = '{
        8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h42, 8'h4F, 8'h54
    };

    assign quiet = (cyc >= QUIET_START) && (cyc < QUIET_END);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (cyc == HOLD_START) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        logic hs;
        while (!quiet && ($urandom_range(99) < IDLE_PERCENT)) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do begin
            @(negedge i_clk);
            hs = rx_ch.ready;
            @(posedge i_clk);
        end while (!hs);
    endtask

    task automatic settle_block();
        rx_ch.valid <= 1'b0;
        do @(negedge i_clk); while (n_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        logic hs;
        cfg_ch.valid     <= 1'b1;
        cfg_ch.load_base <= v;
        do begin
            @(negedge i_clk);
            hs = cfg_ch.ready;
            @(posedge i_clk);
        end while (!hs);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] seg_base [NUM_SEGMENTS];
        logic [31:0] payload_len;
        logic [7:0]  b;
        int          seg;

        seg_base[0] = mlpl_pkg::LOAD_BASE_RESET;
        seg_base[1] = 32'h0000_0000;
        seg_base[2] = 32'hFFFF_FFFF;
        seg_base[3] = 32'hFFFF_FF00;
        seg_base[4] = $urandom;
        seg_base[5] = 32'h8000_0000;

        i_rst_n          <= 1'b0;
        rx_ch.valid      <= 1'b0;
        rx_ch.rx_byte    <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.load_base <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (hunt_bytes[i]) send_byte(hunt_bytes[i]);

        // Noise never holds T, so the frame below is the only one found
        for (int i = 0; i < NOISE_BYTES; i++) begin
            case ($urandom_range(0, 3))
                0: b = mlpl_pkg::MAGIC_B;
                1: b = mlpl_pkg::MAGIC_O;
                default: begin
                    b = 8'($urandom_range(0, 255));
                    if (b == mlpl_pkg::MAGIC_T) b = ~b;
                end
            endcase
            send_byte(b);
        end

        payload_len = 32'(1500 + $urandom_range(0, 100));
        send_byte(mlpl_pkg::MAGIC_B);
        send_byte(mlpl_pkg::MAGIC_O);
        send_byte(mlpl_pkg::MAGIC_O);
        send_byte(mlpl_pkg::MAGIC_T);
        send_byte(payload_len[7:0]);
        send_byte(payload_len[15:8]);
        send_byte(payload_len[23:16]);
        send_byte(payload_len[31:24]);

        // Move load_base between segments; the payload keeps its offset
        seg = 0;
        for (int k = 0; k < int'(payload_len); k++) begin
            if (seg < NUM_SEGMENTS - 1 && k == (seg + 1) * int'(payload_len) / NUM_SEGMENTS)
            begin
                seg++;
                settle_block();
                write_base(seg_base[seg]);
            end
            b = (k < 9) ? corner_bytes[k] : 8'($urandom_range(0, 255));
            send_byte(b);
        end

        // Frame complete: everything after is dropped
        send_byte(mlpl_pkg::MAGIC_B);
        send_byte(mlpl_pkg::MAGIC_O);
        send_byte(mlpl_pkg::MAGIC_O);
        send_byte(mlpl_pkg::MAGIC_T);
        for (int i = 0; i < TAIL_BYTES; i++) send_byte(8'($urandom_range(0, 255)));

        settle_block();
        @(negedge i_clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
